@@ rtl/core/sitda_pkg.sv @@
// Package for the signed integer to decimal ASCII converter.
// Holds shared constants, the digit count function and the controller/datapath structs.
// No dependencies.
`default_nettype none

package sitda_pkg;

	localparam int DEFAULT_VALUE_BITS = 32;
	localparam int CHAR_BITS = 6;
	localparam int DIGIT_BITS = 4;

	localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;
	localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
	localparam logic [DIGIT_BITS-1:0] DABBLE_ADD = 4'd3;

	// Decimal digits needed for any value below 2**w, from log10(2) ~ 1233/4096.
	function automatic int bcd_digits(input int w);
		return ((w * 1233) >> 12) + 1;
	endfunction

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic conv_step;
		logic shift_digit;
		logic sel_sign;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_last;
		logic top_zero;
		logic last_digit;
		logic negative;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/core/sitda_in_if.sv @@
// Input channel of the converter: one signed integer per transfer.
// Depends on nothing; the width is a parameter.
`default_nettype none

interface sitda_in_if #(
	parameter int VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sitda_out_if.sv @@
// Output channel of the converter: one ASCII character and a last flag per transfer.
// Depends on sitda_pkg for the character width.
`default_nettype none

interface sitda_out_if
	import sitda_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CHAR_BITS-1:0] character;
	logic                 last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/signed_int_to_decimal_ascii_top.sv @@
// Signed integer to decimal ASCII text, one character per output transfer.
// The first character follows the bit-serial double-dabble loop (one input bit per cycle) and the
// leading-zero skip; characters then go out one per cycle while the receiver is ready, and a new
// number is taken only in idle, after the last character of the previous one has been transferred.
// Reset (arst_n low, asynchronous) returns the controller to idle; no number is in flight.
// Depends on sitda_pkg, sitda_in_if, sitda_out_if, sitda_ctrl and sitda_datapath.
`default_nettype none

module signed_int_to_decimal_ascii_top
	import sitda_pkg::*;
#(
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sitda_in_if.sink  num,
	sitda_out_if.source text
);

	cmd_t    cmd;
	status_t status;

	sitda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (num.valid),
		.in_ready  (num.ready),
		.out_valid (text.valid),
		.out_ready (text.ready),
		.status    (status),
		.cmd       (cmd)
	);

	sitda_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (num.value),
		.cmd       (cmd),
		.status    (status),
		.character (text.character),
		.last      (text.last)
	);

endmodule

`default_nettype wire

@@ rtl/core/sitda_datapath.sv @@
// Datapath of the converter: magnitude register, bit-serial double-dabble BCD register,
// and the character formatter. Depends on sitda_pkg.
`default_nettype none

module sitda_datapath
	import sitda_pkg::*;
#(
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire cmd_t                  cmd,
	output status_t                    status,
	output logic [CHAR_BITS-1:0]       character,
	output logic                       last
);

	localparam int NDIG = bcd_digits(VALUE_BITS);
	localparam int BCD_BITS = NDIG * DIGIT_BITS;
	localparam int BCW = $clog2(VALUE_BITS + 1);
	localparam int DCW = $clog2(NDIG + 1);

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic                  neg_q;
	logic [BCW-1:0]        bit_cnt_q;
	logic [DCW-1:0]        dig_cnt_q;

	logic [BCD_BITS-1:0]   bcd_adj;
	logic [DIGIT_BITS-1:0] top_digit;

	// Each BCD digit of 5 or more gets 3 added before the shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT) begin
				bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
					bcd_q[i*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADD;
			end else begin
				bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= BCW'(VALUE_BITS);
			dig_cnt_q <= DCW'(NDIG);
		end else if (cmd.conv_step) begin
			bit_cnt_q <= bit_cnt_q - BCW'(1);
		end else if (cmd.shift_digit) begin
			dig_cnt_q <= dig_cnt_q - DCW'(1);
		end
	end

	// The magnitude is the unsigned negation within the word, so the most
	// negative value converts correctly.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[VALUE_BITS-1];
			mag_q <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
			bcd_q <= '0;
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[BCD_BITS-2:0], mag_q[VALUE_BITS-1]};
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end else if (cmd.shift_digit) begin
			bcd_q <= {bcd_q[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
		end
	end

	assign top_digit = bcd_q[BCD_BITS-1 -: DIGIT_BITS];

	assign status.conv_last  = (bit_cnt_q == BCW'(1));
	assign status.top_zero   = (top_digit == '0);
	assign status.last_digit = (dig_cnt_q == DCW'(1));
	assign status.negative   = neg_q;

	assign character = cmd.sel_sign ? ASCII_MINUS
		: (ASCII_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, top_digit});
	assign last = !cmd.sel_sign && status.last_digit;

endmodule

`default_nettype wire

@@ rtl/core/sitda_ctrl.sv @@
// Controller of the converter: sequences load, conversion, leading-zero skip and
// character emission. Depends on sitda_pkg.
`default_nettype none

module sitda_ctrl
	import sitda_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CONV  = 5'b00010,
		S_SKIP  = 5'b00100,
		S_SIGN  = 5'b01000,
		S_DIGIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (status.conv_last) begin
					state_d = S_SKIP;
				end
			end
			// Leading zeros are dropped, but the units digit always stays.
			S_SKIP: begin
				if (status.top_zero && !status.last_digit) begin
					cmd.shift_digit = 1'b1;
				end else if (status.negative) begin
					state_d = S_SIGN;
				end else begin
					state_d = S_DIGIT;
				end
			end
			S_SIGN: begin
				cmd.sel_sign = 1'b1;
				out_valid    = 1'b1;
				if (out_ready) begin
					state_d = S_DIGIT;
				end
			end
			S_DIGIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.shift_digit = 1'b1;
					if (status.last_digit) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ tb/signed_int_to_decimal_ascii_top_tb.sv @@
// Self-checking testbench for the signed integer to decimal ASCII converter.
// Predicts each number's text on the input transfer and checks every character transfer.
// Depends on sitda_pkg, sitda_in_if, sitda_out_if and signed_int_to_decimal_ascii_top.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_top_tb;
	import sitda_pkg::*;

	localparam int VALUE_BITS = DEFAULT_VALUE_BITS;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_LIMIT = 10;
	// A number occupies the block for its bit-serial pass plus at most 11 characters.
	localparam int SETTLE_CYCLES = 2 * (VALUE_BITS + 24);

	typedef struct packed {
		logic [CHAR_BITS-1:0] character;
		logic                 last;
	} text_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sitda_in_if #(.VALUE_BITS(VALUE_BITS)) num_if ();
	sitda_out_if text_if ();

	signed_int_to_decimal_ascii_top #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.num(num_if),
		.text(text_if)
	);

	text_char_t pending_text[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit gaps_enabled = 1'b1;
	int hold_request = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones, none at all while gaps are disabled.
	function automatic int pick_gap();
		int r;
		if (!gaps_enabled)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch at cycle %0d: %s expected %0d, got %0d", cycle_count, what,
				want, got);
	endtask

	// Expected text of one number: optional minus sign, then the digits without leading
	// zeros. The magnitude is the unsigned negation, so the most negative value works too.
	function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
		logic [VALUE_BITS-1:0] magnitude;
		logic [DIGIT_BITS-1:0] digits[$];
		text_char_t item;
		magnitude = raw[VALUE_BITS-1] ? -raw : raw;
		do begin
			digits.push_front(DIGIT_BITS'(magnitude % 10));
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		if (raw[VALUE_BITS-1]) begin
			item.character = ASCII_MINUS;
			item.last = 1'b0;
			pending_text.push_back(item);
		end
		foreach (digits[i]) begin
			item.character = ASCII_ZERO + CHAR_BITS'(digits[i]);
			item.last = (i == digits.size() - 1);
			pending_text.push_back(item);
		end
	endfunction

	task automatic send_number(input logic [VALUE_BITS-1:0] number);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			num_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		num_if.valid = 1'b1;
		num_if.value = number;
		do @(posedge clk); while (!num_if.ready);
		predict_text(number);
	endtask

	task automatic wait_for_text();
		@(negedge clk);
		num_if.valid = 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
	endtask

	// Random magnitudes spread over every digit count, with the bounds of each decade
	// hit now and then, plus fully random bit patterns.
	function automatic logic [VALUE_BITS-1:0] random_number();
		longint unsigned lo;
		longint unsigned hi;
		logic [VALUE_BITS-1:0] magnitude;
		int n_digits;
		int pick;
		bit negative;
		if ($urandom_range(9) < 2)
			return $urandom();
		negative = 1'($urandom_range(1));
		n_digits = $urandom_range(10, 1);
		lo = 1;
		for (int i = 1; i < n_digits; i++)
			lo = lo * 10;
		hi = lo * 10 - 1;
		if (n_digits == 1)
			lo = 0;
		if (hi > 64'd2147483647)
			hi = negative ? 64'd2147483648 : 64'd2147483647;
		pick = $urandom_range(9);
		if (pick == 0)
			magnitude = lo[VALUE_BITS-1:0];
		else if (pick == 1)
			magnitude = hi[VALUE_BITS-1:0];
		else
			magnitude = $urandom_range(hi[31:0], lo[31:0]);
		return negative ? -magnitude : magnitude;
	endfunction

	initial begin
		num_if.valid = 1'b0;
		num_if.value = '0;
	end

	// Receiver: random stalls, plus a long hold-off whenever a test asks for one.
	initial text_if.ready = 1'b0;
	always @(negedge clk) begin : receiver
		int stall_left;
		int hold_left;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (!arst_n) begin
			text_if.ready = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			text_if.ready = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			text_if.ready = 1'b0;
		end else begin
			text_if.ready = 1'b1;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : text_checker
		text_char_t want;
		if (text_if.valid && text_if.ready) begin
			if (pending_text.size() == 0) begin
				note_mismatch("unexpected character transfer, code", -1, text_if.character);
			end else begin
				want = pending_text.pop_front();
				if (text_if.character !== want.character)
					note_mismatch("character", want.character, text_if.character);
				if (text_if.last !== want.last)
					note_mismatch("last flag", want.last, text_if.last);
			end
		end
	end

	task automatic test_extremes();
		logic [VALUE_BITS-1:0] numbers[$];
		numbers = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99,
			32'd100, -32'sd100, 32'd2147483647, 32'h8000_0000, 32'h8000_0001,
			32'd1000000000, -32'sd1000000000, 32'd999999999, 32'd123456789,
			32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000, 32'd101, -32'sd7};
		gaps_enabled = 1'b1;
		foreach (numbers[i])
			send_number(numbers[i]);
		wait_for_text();
	endtask

	task automatic test_random_back_to_back(input int count);
		gaps_enabled = 1'b0;
		repeat (count)
			send_number(random_number());
		wait_for_text();
	endtask

	task automatic test_random_with_gaps(input int count);
		gaps_enabled = 1'b1;
		repeat (count)
			send_number(random_number());
		wait_for_text();
	endtask

	// The receiver stops for a long stretch while numbers keep coming, so the block
	// fills up and has to refuse further input transfers.
	task automatic test_output_backpressure(input int count);
		gaps_enabled = 1'b0;
		hold_request = 500;
		repeat (count)
			send_number(random_number());
		gaps_enabled = 1'b1;
		wait_for_text();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_random_back_to_back(50);
		test_output_backpressure(20);
		test_random_with_gaps(118);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_text.size() != 0)
			note_mismatch("characters still expected", 0, pending_text.size());
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ signed_int_to_decimal_ascii_top.f @@
rtl/core/sitda_pkg.sv
rtl/core/sitda_in_if.sv
rtl/core/sitda_out_if.sv
rtl/core/sitda_datapath.sv
rtl/core/sitda_ctrl.sv
rtl/core/signed_int_to_decimal_ascii_top.sv
tb/signed_int_to_decimal_ascii_top_tb.sv
